[hw/rtl/cfwe_pkg.sv]
// ----------------------------------------------------------------------------
// Cassette FSK wave encoder package
// Payload types, kind codes, sample patterns and controller states.
// ----------------------------------------------------------------------------
package cfwe_pkg;

   localparam logic [1:0] FUNC_LEADER = 2'd0;
   localparam logic [1:0] FUNC_SLOW   = 2'd1;
   localparam logic [1:0] FUNC_FAST   = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam int FRAME_BITS = 12;
   localparam int COUNT_BITS = 4;

   localparam logic [COUNT_BITS-1:0] LEADER_NBITS = 4'd8;
   localparam logic [COUNT_BITS-1:0] FRAMED_NBITS = 4'd12;

   localparam logic [3:0] SLOW_SAMPLES = 4'd8;
   localparam logic [3:0] FAST_SAMPLES = 4'd2;

   // Patterns packed with the first sample in bit 0.
   localparam logic [7:0] SLOW_ZERO_POS = 8'hAA;
   localparam logic [7:0] SLOW_ZERO_NEG = 8'h55;
   localparam logic [7:0] SLOW_ONE_POS  = 8'hCC;
   localparam logic [7:0] SLOW_ONE_NEG  = 8'h33;
   localparam logic [7:0] FAST_ZERO_POS = 8'h02;
   localparam logic [7:0] FAST_ZERO_NEG = 8'h01;
   localparam logic [7:0] FAST_ONE_POS  = 8'h00;
   localparam logic [7:0] FAST_ONE_NEG  = 8'h03;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic [7:0] samples;
      logic [3:0] sample_count;
      logic       last_bit;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic load;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic kind_used;
      logic out_free;
      logic last;
   } status_type;

endpackage

[hw/rtl/cfwe_ctrl.sv]
// ----------------------------------------------------------------------------
// Cassette FSK wave encoder controller
// Sequences byte loads and per-bit result emission.
// ----------------------------------------------------------------------------
module cfwe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cfwe_pkg::status_type  status,
   output cfwe_pkg::cmd_type     cmd
);

   cfwe_pkg::state_type state_ff;
   cfwe_pkg::state_type state_in;
   logic                accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfwe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      cmd.emit  = 1'b0;
      unique case (state_ff)
         cfwe_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (accept && status.kind_used) begin
               state_in = cfwe_pkg::ST_SEND;
            end
         end
         cfwe_pkg::ST_SEND: begin
            cmd.emit = status.out_free;
            // The next byte may enter in the cycle that the final bit leaves.
            req_stall = !(status.out_free && status.last);
            if (status.out_free && status.last) begin
               state_in = (accept && status.kind_used) ? cfwe_pkg::ST_SEND
                                                       : cfwe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cfwe_pkg::ST_IDLE;
         end
      endcase
      cmd.load = accept && status.kind_used;
   end

endmodule

[hw/rtl/cfwe_datapath.sv]
// ----------------------------------------------------------------------------
// Cassette FSK wave encoder datapath
// Frame shift register, bit counter, polarity and the result register.
// ----------------------------------------------------------------------------
module cfwe_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  cfwe_pkg::req_type     req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cfwe_pkg::rsp_type     rsp_payload,
   input  cfwe_pkg::cmd_type     cmd,
   output cfwe_pkg::status_type  status
);

   logic [cfwe_pkg::FRAME_BITS-1:0] frame_ff, frame_in;
   logic [cfwe_pkg::COUNT_BITS-1:0] left_ff, left_in;
   logic                            fast_ff, fast_in;
   logic                            polarity_ff, polarity_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   cfwe_pkg::rsp_type               rsp_ff, rsp_in;
   logic                            bit_now;
   logic [7:0]                      wave;

   assign bit_now = frame_ff[0];

   always_comb begin
      if (!fast_ff) begin
         if (!bit_now) wave = polarity_ff ? cfwe_pkg::SLOW_ZERO_POS : cfwe_pkg::SLOW_ZERO_NEG;
         else          wave = polarity_ff ? cfwe_pkg::SLOW_ONE_POS  : cfwe_pkg::SLOW_ONE_NEG;
      end else begin
         if (!bit_now) wave = polarity_ff ? cfwe_pkg::FAST_ZERO_POS : cfwe_pkg::FAST_ZERO_NEG;
         else          wave = polarity_ff ? cfwe_pkg::FAST_ONE_POS  : cfwe_pkg::FAST_ONE_NEG;
      end
   end

   always_comb begin
      frame_in     = frame_ff;
      left_in      = left_ff;
      fast_in      = fast_ff;
      polarity_in  = polarity_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_in.samples      = wave;
         rsp_in.sample_count = fast_ff ? cfwe_pkg::FAST_SAMPLES : cfwe_pkg::SLOW_SAMPLES;
         rsp_in.last_bit     = (left_ff == cfwe_pkg::COUNT_BITS'(1));
         rsp_valid_in        = 1'b1;
         frame_in            = {1'b0, frame_ff[cfwe_pkg::FRAME_BITS-1:1]};
         left_in             = left_ff - cfwe_pkg::COUNT_BITS'(1);
         // Every one bit at 2400 baud flips the polarity after its wave.
         if (fast_ff && bit_now) begin
            polarity_in = !polarity_ff;
         end
      end
      if (cmd.load) begin
         fast_in = (req_payload.func == cfwe_pkg::FUNC_FAST);
         if (req_payload.func == cfwe_pkg::FUNC_LEADER) begin
            frame_in = {4'b0000, req_payload.byte_value};
            left_in  = cfwe_pkg::LEADER_NBITS;
         end else begin
            frame_in = {3'b111, req_payload.byte_value, 1'b0};
            left_in  = cfwe_pkg::FRAMED_NBITS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         polarity_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         polarity_ff  <= polarity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      fast_ff  <= fast_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload      = rsp_ff;
   assign status.kind_used = (req_payload.func != cfwe_pkg::FUNC_UNUSED);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.last      = (left_ff == cfwe_pkg::COUNT_BITS'(1));

endmodule

[hw/rtl/cassette_fsk_wave_encoder_unit.sv]
// ----------------------------------------------------------------------------
// Cassette FSK wave encoder
// Turns tape bytes into one-bit waveform samples, one result beat per bit.
// ----------------------------------------------------------------------------
// The request channel carries a byte and its kind: leader/gap bytes send
// 8 unframed bits at 600 baud, data bytes send a start bit, 8 data bits and
// three stop bits at 600 or 2400 baud. Kind 3 is taken and dropped.
// Each response beat holds the samples of one bit, their count and a flag
// on the final bit of the byte.
// The first response beat appears once the byte has passed through the frame
// shift register and then the output register; further beats follow one per
// cycle while the receiver does not stall, from the frame shift register and
// bit counter in the datapath. The next byte is taken in the cycle that the
// final bit enters the output register, so at full rate no gap falls between bytes.
// Reset empties the output register, returns the controller to idle and
// sets the polarity positive. The polarity carries over from byte to byte.
// While the receiver stalls, the output register holds its beat and the
// controller waits; the request channel stalls once a byte is in progress.
// ----------------------------------------------------------------------------
module cassette_fsk_wave_encoder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cfwe_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cfwe_pkg::rsp_type rsp_payload
);

   cfwe_pkg::cmd_type    cmd;
   cfwe_pkg::status_type status;

   cfwe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cfwe_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

[bench/tb_cassette_fsk_wave_encoder_unit.sv]
// ----------------------------------------------------------------------------
// Cassette FSK wave encoder testbench
// Sends leader, slow data and fast data bytes through the encoder and checks
// every bit beat against a local wave predictor that tracks the line
// polarity. A short directed table comes first, then random bytes, with
// random idling on both channels.
// ----------------------------------------------------------------------------
module tb_cassette_fsk_wave_encoder_unit;

   localparam int RANDOM_BYTES = 480;
   localparam int DRAIN_CYCLES = 20;

   // One directed row: the request and, where it is obvious, its first beat.
   typedef struct packed {
      logic [1:0] func;
      logic [7:0] byte_value;
      logic       pinned;
      logic [7:0] samples;
      logic [3:0] sample_count;
      logic       last_bit;
   } dir_row_type;

   localparam int NUM_ROWS = 22;
   localparam dir_row_type DIRECTED [NUM_ROWS] = '{
      // Polarity is positive after reset; slow bytes keep it.
      '{cfwe_pkg::FUNC_LEADER, 8'h00, 1'b1,
        cfwe_pkg::SLOW_ZERO_POS, cfwe_pkg::SLOW_SAMPLES, 1'b0},
      '{cfwe_pkg::FUNC_LEADER, 8'hFF, 1'b1,
        cfwe_pkg::SLOW_ONE_POS,  cfwe_pkg::SLOW_SAMPLES, 1'b0},
      '{cfwe_pkg::FUNC_UNUSED, 8'hA5, 1'b0, 8'h00, 4'd0, 1'b0},
      '{cfwe_pkg::FUNC_SLOW,   8'h00, 1'b1,
        cfwe_pkg::SLOW_ZERO_POS, cfwe_pkg::SLOW_SAMPLES, 1'b0},
      '{cfwe_pkg::FUNC_SLOW,   8'hFF, 1'b1,
        cfwe_pkg::SLOW_ZERO_POS, cfwe_pkg::SLOW_SAMPLES, 1'b0},
      // Three stop bits flip the polarity an odd number of times.
      '{cfwe_pkg::FUNC_FAST,   8'h00, 1'b1,
        cfwe_pkg::FAST_ZERO_POS, cfwe_pkg::FAST_SAMPLES, 1'b0},
      '{cfwe_pkg::FUNC_LEADER, 8'h00, 1'b1,
        cfwe_pkg::SLOW_ZERO_NEG, cfwe_pkg::SLOW_SAMPLES, 1'b0},
      '{cfwe_pkg::FUNC_LEADER, 8'hFF, 1'b1,
        cfwe_pkg::SLOW_ONE_NEG,  cfwe_pkg::SLOW_SAMPLES, 1'b0},
      '{cfwe_pkg::FUNC_SLOW,   8'h80, 1'b1,
        cfwe_pkg::SLOW_ZERO_NEG, cfwe_pkg::SLOW_SAMPLES, 1'b0},
      '{cfwe_pkg::FUNC_UNUSED, 8'h00, 1'b0, 8'h00, 4'd0, 1'b0},
      '{cfwe_pkg::FUNC_UNUSED, 8'hFF, 1'b0, 8'h00, 4'd0, 1'b0},
      '{cfwe_pkg::FUNC_FAST,   8'hFF, 1'b1,
        cfwe_pkg::FAST_ZERO_NEG, cfwe_pkg::FAST_SAMPLES, 1'b0},
      '{cfwe_pkg::FUNC_FAST,   8'h01, 1'b0, 8'h00, 4'd0, 1'b0},
      '{cfwe_pkg::FUNC_FAST,   8'h55, 1'b0, 8'h00, 4'd0, 1'b0},
      '{cfwe_pkg::FUNC_SLOW,   8'h01, 1'b0, 8'h00, 4'd0, 1'b0},
      '{cfwe_pkg::FUNC_SLOW,   8'hAA, 1'b0, 8'h00, 4'd0, 1'b0},
      '{cfwe_pkg::FUNC_LEADER, 8'h55, 1'b0, 8'h00, 4'd0, 1'b0},
      '{cfwe_pkg::FUNC_LEADER, 8'hAA, 1'b0, 8'h00, 4'd0, 1'b0},
      '{cfwe_pkg::FUNC_FAST,   8'hAA, 1'b0, 8'h00, 4'd0, 1'b0},
      '{cfwe_pkg::FUNC_FAST,   8'h80, 1'b0, 8'h00, 4'd0, 1'b0},
      '{cfwe_pkg::FUNC_LEADER, 8'h01, 1'b0, 8'h00, 4'd0, 1'b0},
      '{cfwe_pkg::FUNC_LEADER, 8'h80, 1'b0, 8'h00, 4'd0, 1'b0}
   };

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   cfwe_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_stall;
   cfwe_pkg::rsp_type rsp_payload;

   // Predictor state and the queue of bit beats still owed by the block.
   logic              line_positive;
   cfwe_pkg::rsp_type wave_beats_due [$];
   int                error_count;
   int                idle_pct;

   // First beat typed in by the directed table for the byte being offered.
   logic              pin_first;
   cfwe_pkg::rsp_type pin_beat;

   cassette_fsk_wave_encoder_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   // Works out the bit beats of one accepted byte and updates the polarity.
   task automatic encode_byte(input cfwe_pkg::req_type r, input logic pinned,
                              input cfwe_pkg::rsp_type pin);
      logic [11:0]       frame;
      int                nbits;
      logic              fast;
      logic              bit_val;
      cfwe_pkg::rsp_type beat;
      if (r.func == cfwe_pkg::FUNC_UNUSED) return;
      if (r.func == cfwe_pkg::FUNC_LEADER) begin
         frame = {4'b0000, r.byte_value};
         nbits = 8;
      end else begin
         frame = {3'b111, r.byte_value, 1'b0};
         nbits = 12;
      end
      fast = (r.func == cfwe_pkg::FUNC_FAST);
      for (int k = 0; k < nbits; k++) begin
         bit_val = frame[k];
         if (!fast) begin
            if (bit_val) beat.samples = line_positive ? cfwe_pkg::SLOW_ONE_POS
                                                      : cfwe_pkg::SLOW_ONE_NEG;
            else         beat.samples = line_positive ? cfwe_pkg::SLOW_ZERO_POS
                                                      : cfwe_pkg::SLOW_ZERO_NEG;
            beat.sample_count = cfwe_pkg::SLOW_SAMPLES;
         end else begin
            if (bit_val) begin
               beat.samples  = line_positive ? cfwe_pkg::FAST_ONE_POS
                                             : cfwe_pkg::FAST_ONE_NEG;
               line_positive = ~line_positive;
            end else begin
               beat.samples = line_positive ? cfwe_pkg::FAST_ZERO_POS
                                            : cfwe_pkg::FAST_ZERO_NEG;
            end
            beat.sample_count = cfwe_pkg::FAST_SAMPLES;
         end
         beat.last_bit = (k == nbits - 1);
         if (k == 0 && pinned) wave_beats_due.insert(wave_beats_due.size(), pin);
         else                  wave_beats_due.insert(wave_beats_due.size(), beat);
      end
   endtask

   // Offers one byte after a random idle gap and waits for it to be taken.
   task automatic send_byte(input cfwe_pkg::req_type r, input logic pinned,
                            input cfwe_pkg::rsp_type pin);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      pin_first = pinned;
      pin_beat  = pin;
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < idle_pct);
   end

   always @(posedge clock) begin : monitor
      cfwe_pkg::rsp_type due;
      if (!reset) begin
         if (req_valid && !req_stall) encode_byte(req_payload, pin_first, pin_beat);
         if (rsp_valid && !rsp_stall) begin
            if (wave_beats_due.size() == 0) begin
               $error("unexpected beat: samples %h count %0d last %0d",
                      rsp_payload.samples, rsp_payload.sample_count, rsp_payload.last_bit);
               error_count++;
            end else begin
               due = wave_beats_due.pop_front();
               if (rsp_payload.samples !== due.samples) begin
                  $error("samples: expected %h, got %h", due.samples, rsp_payload.samples);
                  error_count++;
               end
               if (rsp_payload.sample_count !== due.sample_count) begin
                  $error("sample_count: expected %0d, got %0d",
                         due.sample_count, rsp_payload.sample_count);
                  error_count++;
               end
               if (rsp_payload.last_bit !== due.last_bit) begin
                  $error("last_bit: expected %0d, got %0d", due.last_bit, rsp_payload.last_bit);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      #400000;
      $display("tb_cassette_fsk_wave_encoder_unit: done, errors");
      $finish;
   end

   initial begin : stimulus
      cfwe_pkg::req_type r;
      cfwe_pkg::rsp_type no_pin;
      int                sent;
      int                roll;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      line_positive = 1'b1;
      error_count   = 0;
      idle_pct      = 31;
      pin_first     = 1'b0;
      pin_beat      = '0;
      no_pin        = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[i]) begin
         r.func       = DIRECTED[i].func;
         r.byte_value = DIRECTED[i].byte_value;
         send_byte(r, DIRECTED[i].pinned,
                   '{DIRECTED[i].samples, DIRECTED[i].sample_count, DIRECTED[i].last_bit});
      end

      sent = 0;
      while (sent < RANDOM_BYTES) begin
         // A long stretch at full rate on both channels.
         idle_pct = (sent >= 200 && sent < 300) ? 0 : 31;
         roll = $urandom_range(0, 99);
         if (roll < 4) r.func = cfwe_pkg::FUNC_UNUSED;
         else          r.func = 2'($urandom_range(0, 2));
         case ($urandom_range(0, 7))
            0:       r.byte_value = 8'h00;
            1:       r.byte_value = 8'hFF;
            default: r.byte_value = 8'($urandom_range(0, 255));
         endcase
         send_byte(r, 1'b0, no_pin);
         if (r.func != cfwe_pkg::FUNC_UNUSED) sent++;
      end
      req_valid <= 1'b0;

      while (wave_beats_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && wave_beats_due.size() == 0) begin
         $display("tb_cassette_fsk_wave_encoder_unit: done, clean");
      end else begin
         $display("tb_cassette_fsk_wave_encoder_unit: done, errors");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/cfwe_pkg.sv
hw/rtl/cfwe_ctrl.sv
hw/rtl/cfwe_datapath.sv
hw/rtl/cassette_fsk_wave_encoder_unit.sv
bench/tb_cassette_fsk_wave_encoder_unit.sv
